// ===== design/xoshiro_pkg.sv =====
`default_nettype none

package xoshiro_pkg;

    // Request codes carried by the mode field of an input beat.
    localparam logic [1:0] MODE_NEXT = 2'd0;
    localparam logic [1:0] MODE_SEED = 2'd1;
    localparam logic [1:0] MODE_JUMP = 2'd2;

    // Seeder constants.
    localparam logic [63:0] SEED_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SEED_MUL1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SEED_MUL2   = 64'h94D049BB133111EB;

    // Long-jump polynomial, word 0 in the low bits, so bit 64*w+b is bit b of word w.
    localparam logic [255:0] LONG_JUMP_POLY = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    // Shift and rotate amounts of the generator.
    localparam int unsigned ROT_OUT   = 23;
    localparam int unsigned SHIFT_S1  = 17;
    localparam int unsigned ROT_S3    = 45;

    // Seeder step count per state word.
    localparam int unsigned SEED_STEPS = 9;
    localparam int unsigned STEP_W     = $clog2(SEED_STEPS);

    // Operations the controller asks of the datapath.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_NEXT,
        DP_SEED_LOAD,
        DP_INC,
        DP_MUL_LO,
        DP_MUL_HL,
        DP_MUL_LH,
        DP_MIX,
        DP_WRITE,
        DP_JUMP_START,
        DP_JUMP_STEP,
        DP_JUMP_END
    } t_dp_op;

    // Command bundle from controller to datapath.
    typedef struct packed {
        t_dp_op     op;
        logic       const_sel;  // 0 selects the first mixer constant, 1 the second
        logic [1:0] word;       // state word written by the seeder
        logic       poly_bit;   // current jump polynomial bit
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== design/xoshiro_ctrl.sv =====
`default_nettype none

module xoshiro_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [1:0]          i_mode,
    input  wire logic                i_out_ready,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output xoshiro_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_JUMP,
        ST_JEND
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_out_valid, n_out_valid;
    logic [7:0]                      r_cnt, n_cnt;
    logic [xoshiro_pkg::STEP_W-1:0]  r_step, n_step;
    logic [1:0]                      r_word, n_word;
    logic                            in_accept;

    // A new beat is taken only when idle and the output register is free or draining.
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next-state and command decode.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_word      = r_word;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op        = xoshiro_pkg::DP_NOP;
        o_cmd.const_sel = 1'b0;
        o_cmd.word      = r_word;
        o_cmd.poly_bit  = xoshiro_pkg::LONG_JUMP_POLY[r_cnt];
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_mode)
                        xoshiro_pkg::MODE_NEXT: begin
                            o_cmd.op    = xoshiro_pkg::DP_NEXT;
                            n_out_valid = 1'b1;
                        end
                        xoshiro_pkg::MODE_SEED: begin
                            o_cmd.op = xoshiro_pkg::DP_SEED_LOAD;
                            n_step   = '0;
                            n_word   = '0;
                            n_state  = ST_SEED;
                        end
                        xoshiro_pkg::MODE_JUMP: begin
                            o_cmd.op = xoshiro_pkg::DP_JUMP_START;
                            n_cnt    = '0;
                            n_state  = ST_JUMP;
                        end
                        default: begin
                            o_cmd.op = xoshiro_pkg::DP_NOP;
                        end
                    endcase
                end
            end
            ST_SEED: begin
                // Each word: increment, multiply, mix, multiply, finish and store.
                n_step = r_step + 1'b1;
                case (r_step)
                    4'd0: o_cmd.op = xoshiro_pkg::DP_INC;
                    4'd1: o_cmd.op = xoshiro_pkg::DP_MUL_LO;
                    4'd2: o_cmd.op = xoshiro_pkg::DP_MUL_HL;
                    4'd3: o_cmd.op = xoshiro_pkg::DP_MUL_LH;
                    4'd4: o_cmd.op = xoshiro_pkg::DP_MIX;
                    4'd5: begin
                        o_cmd.op        = xoshiro_pkg::DP_MUL_LO;
                        o_cmd.const_sel = 1'b1;
                    end
                    4'd6: begin
                        o_cmd.op        = xoshiro_pkg::DP_MUL_HL;
                        o_cmd.const_sel = 1'b1;
                    end
                    4'd7: begin
                        o_cmd.op        = xoshiro_pkg::DP_MUL_LH;
                        o_cmd.const_sel = 1'b1;
                    end
                    4'd8: begin
                        o_cmd.op = xoshiro_pkg::DP_WRITE;
                        n_step   = '0;
                        n_word   = r_word + 1'b1;
                        if (r_word == 2'd3) begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.op = xoshiro_pkg::DP_NOP;
                        n_step   = '0;
                    end
                endcase
            end
            ST_JUMP: begin
                // One generator step per cycle over all 256 polynomial bits.
                o_cmd.op = xoshiro_pkg::DP_JUMP_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == 8'd255) begin
                    n_state = ST_JEND;
                end
            end
            ST_JEND: begin
                o_cmd.op = xoshiro_pkg::DP_JUMP_END;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_word      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_word      <= n_word;
        end
    end

endmodule

`default_nettype wire

// ===== design/xoshiro_dp.sv =====
`default_nettype none

module xoshiro_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire xoshiro_pkg::t_dp_cmd i_cmd,
    input  wire logic [63:0]         i_seed_value,
    output logic [63:0]              o_random_value
);

    logic [63:0] r_state [4];
    logic [63:0] n_state [4];
    logic [63:0] r_sum   [4];
    logic [63:0] r_out;
    logic [63:0] r_acc;
    logic [63:0] r_z;
    logic [63:0] r_prod;

    logic [63:0] adv     [4];
    logic [63:0] out_sum;
    logic [63:0] out_word;
    logic [63:0] t3;
    logic [63:0] k_word;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] acc_inc;

    // One generator step and the output word taken before it.
    always_comb begin
        t3      = r_state[3] ^ r_state[1];
        adv[2]  = r_state[2] ^ r_state[0] ^ (r_state[1] << xoshiro_pkg::SHIFT_S1);
        adv[1]  = r_state[1] ^ r_state[2] ^ r_state[0];
        adv[0]  = r_state[0] ^ t3;
        adv[3]  = {t3[63-xoshiro_pkg::ROT_S3:0], t3[63:64-xoshiro_pkg::ROT_S3]};
        out_sum = r_state[0] + r_state[3];
        out_word = {out_sum[63-xoshiro_pkg::ROT_OUT:0], out_sum[63:64-xoshiro_pkg::ROT_OUT]}
                 + r_state[0];
    end

    // Shared 32x32 multiplier for the seeder's 64-bit products.
    assign k_word  = i_cmd.const_sel ? xoshiro_pkg::SEED_MUL2 : xoshiro_pkg::SEED_MUL1;
    assign mul_a   = (i_cmd.op == xoshiro_pkg::DP_MUL_LH) ? r_z[63:32] : r_z[31:0];
    assign mul_b   = (i_cmd.op == xoshiro_pkg::DP_MUL_HL) ? k_word[63:32] : k_word[31:0];
    assign mul_p   = {32'b0, mul_a} * {32'b0, mul_b};
    assign acc_inc = r_acc + xoshiro_pkg::SEED_GOLDEN;

    // Next state words.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_state[j] = r_state[j];
        end
        case (i_cmd.op)
            xoshiro_pkg::DP_NEXT, xoshiro_pkg::DP_JUMP_STEP: begin
                for (int j = 0; j < 4; j++) begin
                    n_state[j] = adv[j];
                end
            end
            xoshiro_pkg::DP_WRITE: begin
                n_state[i_cmd.word] = r_prod ^ (r_prod >> 31);
            end
            xoshiro_pkg::DP_JUMP_END: begin
                for (int j = 0; j < 4; j++) begin
                    n_state[j] = r_sum[j];
                end
            end
            default: begin
                for (int j = 0; j < 4; j++) begin
                    n_state[j] = r_state[j];
                end
            end
        endcase
    end

    // Generator state resets to all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_state[j] <= '0;
            end
        end else begin
            for (int j = 0; j < 4; j++) begin
                r_state[j] <= n_state[j];
            end
        end
    end

    // Working registers of the seeder, jump accumulator and output word.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            xoshiro_pkg::DP_NEXT: begin
                r_out <= out_word;
            end
            xoshiro_pkg::DP_SEED_LOAD: begin
                r_acc <= i_seed_value;
            end
            xoshiro_pkg::DP_INC: begin
                r_acc <= acc_inc;
                r_z   <= acc_inc ^ (acc_inc >> 30);
            end
            xoshiro_pkg::DP_MUL_LO: begin
                r_prod <= mul_p;
            end
            xoshiro_pkg::DP_MUL_HL, xoshiro_pkg::DP_MUL_LH: begin
                r_prod <= r_prod + {mul_p[31:0], 32'b0};
            end
            xoshiro_pkg::DP_MIX: begin
                r_z <= r_prod ^ (r_prod >> 27);
            end
            xoshiro_pkg::DP_JUMP_START: begin
                for (int j = 0; j < 4; j++) begin
                    r_sum[j] <= '0;
                end
            end
            xoshiro_pkg::DP_JUMP_STEP: begin
                if (i_cmd.poly_bit) begin
                    for (int j = 0; j < 4; j++) begin
                        r_sum[j] <= r_sum[j] ^ r_state[j];
                    end
                end
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

    assign o_random_value = r_out;

endmodule

`default_nettype wire

// ===== design/xoshiro256pp_generator.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_mode, i_seed_value
// out      output     o_out_valid / i_out_ready o_random_value
//
// Back-to-back next beats run one per cycle while the output is drained, since the
// result sits in a single output register.
// A seed beat loads at the accept edge, then the input stays closed while each
// state word in turn passes through the shared 32x32 multiplier.
// A long-jump beat starts at the accept edge, then the input stays closed for one
// generator step per polynomial bit plus a final copy.
// Synchronous active-low reset clears the state words to zero and empties the output.
`default_nettype none

module xoshiro256pp_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_seed_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_random_value
);

    xoshiro_pkg::t_dp_cmd cmd;

    // Sequencer for requests and the output beat.
    xoshiro_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // State words, seeder, jump accumulator and output register.
    xoshiro_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_seed_value   (i_seed_value),
        .o_random_value (o_random_value)
    );

`ifndef NO_ASSERTIONS
    // An accepted next request always presents a result beat in the following cycle.
    a_next_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == xoshiro_pkg::MODE_NEXT) |=> o_out_valid)
        else $error("next request produced no result beat");

    // Seed and jump requests close the input for at least the next cycle.
    a_long_ops_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        ((i_mode == xoshiro_pkg::MODE_SEED) || (i_mode == xoshiro_pkg::MODE_JUMP))
        |=> !o_in_ready)
        else $error("input reopened right after a seed or jump request");

    // A seed request never creates a result beat.
    a_seed_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid && (i_mode == xoshiro_pkg::MODE_SEED)
        |=> !o_out_valid)
        else $error("seed request produced a result beat");

    // While the input is closed, no new result beat appears.
    a_busy_no_new_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result beat appeared during a long operation");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names only the three live request codes.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    localparam int unsigned TAIL_CYCLES   = 300;
    localparam int unsigned RANDOM_BEATS  = 1500;
    localparam int unsigned QUIET_BEATS   = 300;
    localparam int unsigned REPORT_LIMIT  = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [63:0] i_seed_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_random_value;

    xoshiro256pp_generator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_seed_value   (i_seed_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_random_value (o_random_value)
    );

    // Predicted generator state and the output words still owed by the block.
    logic [63:0] gen_words [4];
    logic [63:0] expected_words [$];
    logic [63:0] want_word;

    int unsigned mismatch_count;
    bit          idle_on;
    int unsigned rx_hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Generator prediction
    // ------------------------------------------------------------------

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    // One generator step: returns the output word and advances the state.
    function automatic logic [63:0] step_generator();
        logic [63:0] out_word;
        logic [63:0] shifted;
        out_word = rotl64(gen_words[0] + gen_words[3], xoshiro_pkg::ROT_OUT) + gen_words[0];
        shifted = gen_words[1] << xoshiro_pkg::SHIFT_S1;
        gen_words[2] ^= gen_words[0];
        gen_words[3] ^= gen_words[1];
        gen_words[1] ^= gen_words[2];
        gen_words[0] ^= gen_words[3];
        gen_words[2] ^= shifted;
        gen_words[3] = rotl64(gen_words[3], xoshiro_pkg::ROT_S3);
        return out_word;
    endfunction

    // Four successive splitmix64 outputs of the seed fill the state.
    function automatic void load_seed(input logic [63:0] seed);
        logic [63:0] acc;
        logic [63:0] z;
        acc = seed;
        for (int w = 0; w < 4; w++) begin
            acc = acc + xoshiro_pkg::SEED_GOLDEN;
            z = acc;
            z = (z ^ (z >> 30)) * xoshiro_pkg::SEED_MUL1;
            z = (z ^ (z >> 27)) * xoshiro_pkg::SEED_MUL2;
            gen_words[w] = z ^ (z >> 31);
        end
    endfunction

    // Sum of the states selected by the jump polynomial over 256 steps.
    function automatic void apply_long_jump();
        logic [63:0] acc [4];
        for (int j = 0; j < 4; j++) acc[j] = 64'd0;
        for (int b = 0; b < 256; b++) begin
            if (xoshiro_pkg::LONG_JUMP_POLY[b]) begin
                for (int j = 0; j < 4; j++) acc[j] ^= gen_words[j];
            end
            void'(step_generator());
        end
        for (int j = 0; j < 4; j++) gen_words[j] = acc[j];
    endfunction

    function automatic void predict_beat(input logic [1:0] mode, input logic [63:0] seed);
        case (mode)
            xoshiro_pkg::MODE_NEXT: expected_words.push_back(step_generator());
            xoshiro_pkg::MODE_SEED: load_seed(seed);
            xoshiro_pkg::MODE_JUMP: apply_long_jump();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result beat with nothing expected", 64'd0, o_random_value);
            end else begin
                want_word = expected_words.pop_front();
                if (want_word !== o_random_value) begin
                    report_mismatch("random_value mismatch", want_word, o_random_value);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, plus a long hold on request.
    // ------------------------------------------------------------------

    initial begin
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_request > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold_request) @(posedge i_clk);
                rx_hold_request = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one beat and waits for it to be taken. Valid is left high so that
    // a following beat goes out back to back; a gap or a pause lowers it.
    task automatic send_beat(input logic [1:0] mode, input logic [63:0] seed);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_seed_value <= seed;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_beat(mode, seed);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Stops offering and waits until every owed result has come out.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the state is zero: next gives zero, jump keeps zero.
    // Seed values on non-seed beats must have no effect.
    task automatic test_unseeded_state();
        send_beat(xoshiro_pkg::MODE_NEXT, '1);
        send_beat(xoshiro_pkg::MODE_NEXT, rand64());
        send_beat(xoshiro_pkg::MODE_JUMP, '1);
        send_beat(MODE_UNUSED, rand64());
        send_beat(xoshiro_pkg::MODE_NEXT, 64'd0);
    endtask

    // Seed extremes, every mode, back-to-back seeds and jumps.
    task automatic test_directed_modes();
        send_beat(xoshiro_pkg::MODE_SEED, 64'd0);
        send_beat(xoshiro_pkg::MODE_NEXT, '1);
        send_beat(xoshiro_pkg::MODE_NEXT, 64'd0);
        send_beat(xoshiro_pkg::MODE_SEED, '1);
        send_beat(xoshiro_pkg::MODE_NEXT, rand64());
        send_beat(xoshiro_pkg::MODE_SEED, 64'h8000_0000_0000_0000);
        send_beat(xoshiro_pkg::MODE_NEXT, rand64());
        send_beat(xoshiro_pkg::MODE_SEED, 64'h0000_0000_0000_0001);
        send_beat(MODE_UNUSED, '1);
        send_beat(xoshiro_pkg::MODE_NEXT, rand64());
        send_beat(xoshiro_pkg::MODE_JUMP, rand64());
        send_beat(xoshiro_pkg::MODE_NEXT, '1);
        send_beat(xoshiro_pkg::MODE_NEXT, rand64());
        send_beat(xoshiro_pkg::MODE_SEED, 64'h5555_5555_5555_5555);
        send_beat(xoshiro_pkg::MODE_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(xoshiro_pkg::MODE_NEXT, rand64());
        send_beat(xoshiro_pkg::MODE_JUMP, '1);
        send_beat(xoshiro_pkg::MODE_JUMP, 64'd0);
        send_beat(xoshiro_pkg::MODE_NEXT, rand64());
    endtask

    // The receiver holds off long enough for the output register to fill and
    // the input to close while next beats keep coming.
    task automatic test_output_backpressure();
        rx_hold_request = 150;
        for (int k = 0; k < 60; k++) send_beat(xoshiro_pkg::MODE_NEXT, rand64());
        wait_results_drained();
    endtask

    // Mostly next beats with occasional reseeds, jumps and unused codes.
    task automatic test_random_traffic(input int unsigned beats);
        int unsigned pick;
        for (int unsigned k = 0; k < beats; k++) begin
            if (k == beats / 2) wait_results_drained();
            if (k == beats - QUIET_BEATS) idle_on = 1'b0;
            pick = $urandom_range(0, 199);
            if (pick < 4) begin
                send_beat(xoshiro_pkg::MODE_JUMP, rand64());
            end else if (pick < 12) begin
                send_beat(xoshiro_pkg::MODE_SEED, rand64());
            end else if (pick < 18) begin
                send_beat(MODE_UNUSED, rand64());
            end else begin
                send_beat(xoshiro_pkg::MODE_NEXT, rand64());
            end
        end
    endtask

    initial begin
        mismatch_count  = 0;
        idle_on         = 1'b1;
        rx_hold_request = 0;
        for (int j = 0; j < 4; j++) gen_words[j] = 64'd0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= xoshiro_pkg::MODE_NEXT;
        i_seed_value <= 64'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unseeded_state();
        test_directed_modes();
        test_output_backpressure();
        test_random_traffic(RANDOM_BEATS);

        // Let the last results out, then allow for a trailing long jump.
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
